// ----- hdl/ple_pkg.sv -----
// Shared types and codes for the positional list engine.
// Depends on nothing; ple_seq, the top level and the bench import it.
`timescale 1ns / 1ps

package ple_pkg;

	// default sizing
	localparam int PLE_CAPACITY   = 16;
	localparam int PLE_DATA_WIDTH = 32;

	// field widths fixed by the request and result formats
	localparam int ACTION_W = 4;
	localparam int POS_W    = 5;
	localparam int WORD_W   = 32;

	// operation codes
	localparam logic [ACTION_W-1:0] ACT_INSERT       = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT_FRONT = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_INSERT_BACK  = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_REMOVE       = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_REMOVE_FRONT = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_REMOVE_BACK  = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_SELECT       = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_SEARCH       = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_REPLACE      = 4'd8;

	typedef struct packed {
		logic [ACTION_W-1:0]      action;
		logic [POS_W-1:0]         position_in;
		logic signed [WORD_W-1:0] data_in;
	} ple_cmd_t;

	typedef struct packed {
		logic                     ok;
		logic signed [WORD_W-1:0] data_out;
		logic [POS_W-1:0]         found_position;
		logic [POS_W-1:0]         count;
		logic                     is_empty;
		logic                     is_full;
	} ple_result_t;

endpackage

// ----- hdl/ple_stream_if.sv -----
// Valid/ready stream channel carrying one request or result payload.
// Depends on nothing; the payload type is a parameter, set from ple_pkg types by the bench.
`timescale 1ns / 1ps

interface ple_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/ple_ram.sv -----
// Entry store: one write port, one read port with registered read data.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module ple_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/ple_seq.sv -----
// Operation sequencer: decodes a request and walks the entry store one
// entry per cycle for shifts and searches. Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_seq import ple_pkg::*; #(
	parameter int CAPACITY_ENTRIES = PLE_CAPACITY,
	parameter int DATA_WIDTH       = PLE_DATA_WIDTH,
	localparam int CW = $clog2(CAPACITY_ENTRIES + 1),
	localparam int AW = $clog2(CAPACITY_ENTRIES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  ple_cmd_t              cmd,
	input  logic                  rsp_free,
	output logic                  fin,
	output ple_result_t           res,
	output logic                  ram_we,
	output logic [AW-1:0]         ram_waddr,
	output logic [DATA_WIDTH-1:0] ram_wdata,
	output logic [AW-1:0]         ram_raddr,
	input  logic [DATA_WIDTH-1:0] ram_rdata
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_WRVAL  = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_SELW   = 3'd5;
	localparam logic [2:0] S_FINISH = 3'd6;

	logic [2:0]        state_q;
	ple_cmd_t          cmd_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     p_q;
	logic [CW-1:0]     cur_q;
	logic [CW-1:0]     rem_q;
	logic              up_q;
	logic              lag_v_q;
	logic [AW-1:0]     lag_a_q;
	logic              ok_q;
	logic [WORD_W-1:0] dout_q;
	logic [CW-1:0]     found_q;

	logic [31:0]           pos_w;
	logic [31:0]           cnt_w;
	logic [CW-1:0]         pos_c;
	logic [63:0]           din_ext;
	logic [DATA_WIDTH-1:0] val_w;
	logic [63:0]           rd_ext;
	logic [CW-1:0]         ins_p;
	logic                  ins_ok;
	logic [CW-1:0]         rmv_p;
	logic                  rmv_ok;
	logic [CW-1:0]         sel_a;
	logic                  rep_ok;
	logic [CW-1:0]         cur_dn;
	logic [CW-1:0]         cur_up;
	logic                  hit;
	logic [31:0]           found_w;
	logic [31:0]           cnt_ow;

	// operand views
	assign pos_w   = 32'(cmd_q.position_in);
	assign cnt_w   = 32'(cnt_q);
	assign pos_c   = CW'(cmd_q.position_in);
	assign din_ext = {32'd0, cmd_q.data_in};
	assign val_w   = din_ext[DATA_WIDTH-1:0];
	assign rd_ext  = 64'(ram_rdata);
	assign cur_dn  = cur_q - CW'(1);
	assign cur_up  = cur_q + CW'(1);
	assign hit     = lag_v_q && (ram_rdata == val_w);

	// insert target and admission
	always_comb begin
		unique case (cmd_q.action)
			ACT_INSERT:       ins_p = (pos_w >= cnt_w) ? cnt_q : pos_c;
			ACT_INSERT_FRONT: ins_p = '0;
			default:          ins_p = cnt_q;
		endcase
		ins_ok = (cnt_w < CAPACITY_ENTRIES) &&
			((cmd_q.action != ACT_INSERT) || (pos_w < CAPACITY_ENTRIES));
	end

	// remove target and admission
	always_comb begin
		unique case (cmd_q.action)
			ACT_REMOVE:       rmv_p = pos_c;
			ACT_REMOVE_FRONT: rmv_p = '0;
			default:          rmv_p = cnt_q - CW'(1);
		endcase
		rmv_ok = (cnt_q != '0) && ((cmd_q.action != ACT_REMOVE) || (pos_w < cnt_w));
	end

	// select address clamps to the last entry, replace needs a live entry
	assign sel_a  = (pos_w < cnt_w) ? pos_c : cnt_q - CW'(1);
	assign rep_ok = pos_w < cnt_w;

	// store read address
	assign ram_raddr = (state_q == S_DECODE) ? sel_a[AW-1:0] : cur_q[AW-1:0];

	// store write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = lag_a_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			S_SHIFT: begin
				ram_we = lag_v_q;
			end
			S_WRVAL: begin
				ram_we    = 1'b1;
				ram_waddr = p_q[AW-1:0];
				ram_wdata = val_w;
			end
			S_DECODE: begin
				ram_we    = (cmd_q.action == ACT_REPLACE) && rep_ok;
				ram_waddr = pos_c[AW-1:0];
				ram_wdata = val_w;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// handshake and result
	assign cmd_ready          = (state_q == S_IDLE);
	assign fin                = (state_q == S_FINISH) && rsp_free;
	assign found_w            = 32'(found_q);
	assign cnt_ow             = 32'(cnt_q);
	assign res.ok             = ok_q;
	assign res.data_out       = dout_q;
	assign res.found_position = found_w[POS_W-1:0];
	assign res.count          = cnt_ow[POS_W-1:0];
	assign res.is_empty       = (cnt_q == '0);
	assign res.is_full        = (cnt_w >= CAPACITY_ENTRIES);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			lag_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					lag_v_q <= 1'b0;
					priority case (cmd_q.action)
						ACT_INSERT, ACT_INSERT_FRONT, ACT_INSERT_BACK:
							state_q <= ins_ok ? S_SHIFT : S_FINISH;
						ACT_REMOVE, ACT_REMOVE_FRONT, ACT_REMOVE_BACK:
							state_q <= rmv_ok ? S_SHIFT : S_FINISH;
						ACT_SELECT:
							state_q <= (cnt_q != '0) ? S_SELW : S_FINISH;
						ACT_SEARCH:
							state_q <= S_SCAN;
						default:
							state_q <= S_FINISH;
					endcase
				end
				S_SHIFT: begin
					if (rem_q != '0) begin
						lag_v_q <= 1'b1;
					end else begin
						lag_v_q <= 1'b0;
						if (up_q) begin
							state_q <= S_WRVAL;
						end else begin
							cnt_q   <= cnt_q - CW'(1);
							state_q <= S_FINISH;
						end
					end
				end
				S_WRVAL: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_FINISH;
				end
				S_SCAN: begin
					if (hit || rem_q == '0) begin
						lag_v_q <= 1'b0;
						state_q <= S_FINISH;
					end else begin
						lag_v_q <= 1'b1;
					end
				end
				S_SELW: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
				end
			end
			S_DECODE: begin
				dout_q  <= '0;
				found_q <= '0;
				priority case (cmd_q.action)
					ACT_INSERT, ACT_INSERT_FRONT, ACT_INSERT_BACK: begin
						ok_q  <= ins_ok;
						p_q   <= ins_p;
						cur_q <= cnt_q - CW'(1);
						rem_q <= cnt_q - ins_p;
						up_q  <= 1'b1;
					end
					ACT_REMOVE, ACT_REMOVE_FRONT, ACT_REMOVE_BACK: begin
						ok_q  <= rmv_ok;
						cur_q <= rmv_p + CW'(1);
						rem_q <= cnt_q - CW'(1) - rmv_p;
						up_q  <= 1'b0;
					end
					ACT_SELECT: begin
						ok_q <= 1'b1;
					end
					ACT_SEARCH: begin
						ok_q  <= 1'b1;
						cur_q <= '0;
						rem_q <= cnt_q;
					end
					ACT_REPLACE: begin
						ok_q <= rep_ok;
					end
					default: begin
						ok_q <= 1'b0;
					end
				endcase
			end
			S_SHIFT: begin
				// read one entry, write it one place over next cycle
				if (rem_q != '0) begin
					lag_a_q <= up_q ? cur_up[AW-1:0] : cur_dn[AW-1:0];
					cur_q   <= up_q ? cur_dn : cur_up;
					rem_q   <= rem_q - CW'(1);
				end
			end
			S_SCAN: begin
				// compare the entry read last cycle, read the next one
				if (hit) begin
					found_q <= CW'(lag_a_q);
				end else if (rem_q != '0) begin
					lag_a_q <= cur_q[AW-1:0];
					cur_q   <= cur_up;
					rem_q   <= rem_q - CW'(1);
				end else begin
					found_q <= cnt_q;
				end
			end
			S_SELW: begin
				dout_q <= rd_ext[WORD_W-1:0];
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/positional_list_engine.sv -----
// Top level of the positional list engine: request and result channels,
// result register, sequencer and entry store. Depends on ple_pkg,
// ple_stream_if, ple_seq and ple_ram.
`timescale 1ns / 1ps

// The engine keeps an ordered list of up to CAPACITY_ENTRIES values and runs
// one request at a time: insert at a position, front or back, remove at a
// position, front or back, select, search and replace. Entries sit packed in
// a single-port-write memory, and every shift or search walks it one entry
// per cycle under a small sequencer, so the request channel is not ready
// while a request is in work. An insert moves the entries from its position
// up one place and then writes the value, a remove moves the entries after
// its position down one place, and a search stops at the first match. A
// finished result waits in an output register, and the next request is taken
// while it waits. No clearing pass after reset: entries beyond the count are
// never used.
module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY_ENTRIES = PLE_CAPACITY,
	parameter int DATA_WIDTH       = PLE_DATA_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	ple_stream_if.sink   cmd,
	ple_stream_if.source rsp
);

	localparam int AW = $clog2(CAPACITY_ENTRIES);

	ple_cmd_t              cmd_w;
	ple_result_t           res_w;
	ple_result_t           out_q;
	logic                  out_v_q;
	logic                  fin;
	logic                  rsp_free;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;

	assign cmd_w    = cmd.payload;
	assign rsp_free = !out_v_q || rsp.ready;

	// sequencer
	ple_seq #(
		.CAPACITY_ENTRIES(CAPACITY_ENTRIES),
		.DATA_WIDTH      (DATA_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd.valid),
		.cmd_ready(cmd.ready),
		.cmd      (cmd_w),
		.rsp_free (rsp_free),
		.fin      (fin),
		.res      (res_w),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// entry store
	ple_ram #(
		.DEPTH(CAPACITY_ENTRIES),
		.WIDTH(DATA_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (fin) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fin) begin
			out_q <= res_w;
		end
	end

	assign rsp.valid   = out_v_q;
	assign rsp.payload = out_q;

	// a result completes only while a request is in work
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !cmd.ready)
		else $error("result completed while request channel ready");

	// an accepted request makes the engine busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("engine still ready after accepting a request");

	// a completed result is offered next cycle
	a_fin_offer: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> rsp.valid)
		else $error("completed result not offered");

	// the list cannot be empty and full at once
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.payload.is_empty && rsp.payload.is_full))
		else $error("result reports empty and full together");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the positional list engine: directed table, then random operations.
// Depends on ple_pkg, ple_stream_if and positional_list_engine from the hdl folder.
`timescale 1ns / 1ps

module tb;
	import ple_pkg::*;

	localparam int CLK_HALF_NS   = 6;
	localparam int RESET_CYCLES  = 5;
	localparam int RANDOM_ITEMS  = 1000;
	localparam int STALL_LIMIT   = 5000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_PCT      = 36;
	localparam int PRINT_LIMIT   = 40;
	localparam int DIRECTED_ROWS = 25;
	localparam int HOLD_AT_ITEM  = 400;
	localparam int PAUSE_AT_ITEM = 600;
	localparam int CALM_FIRST    = 700;
	localparam int CALM_LAST     = 850;

	// action codes the block must ignore
	localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd9;
	localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;

	localparam int VALUE_POOL_N = 6;
	localparam logic [WORD_W-1:0] VALUE_POOL [VALUE_POOL_N] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
		32'h7FFF_FFFF, 32'h0000_0001, 32'h55AA_55AA
	};

	typedef enum int {MIX_GROW, MIX_BALANCED, MIX_SHRINK} op_mix_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [POS_W-1:0]    pos;
		logic [WORD_W-1:0]   data;
		logic                fixed;
		ple_result_t         want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	ple_stream_if #(.payload_t(ple_cmd_t))    cmd_if ();
	ple_stream_if #(.payload_t(ple_result_t)) rsp_if ();

	positional_list_engine dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.rsp   (rsp_if)
	);

	// list as the block should hold it
	logic [PLE_DATA_WIDTH-1:0] list_vals [PLE_CAPACITY];
	int unsigned               list_len;

	ple_result_t awaited_results [$];
	stim_row_t   directed_rows [DIRECTED_ROWS];

	// typed-in expectation travelling with the request on offer
	logic        offer_fixed;
	ple_result_t offer_want;

	logic calm;
	logic rsp_hold_req;
	int   mismatch_count;
	int   results_seen;
	int   quiet_cycles;

	initial clk = 1'b0;
	always begin
		#CLK_HALF_NS clk = ~clk;
	end

	function automatic ple_result_t result_of(logic ok, logic [WORD_W-1:0] d, int fp, int cnt,
		logic e, logic f);
		ple_result_t r;
		r.ok             = ok;
		r.data_out       = d;
		r.found_position = POS_W'(fp);
		r.count          = POS_W'(cnt);
		r.is_empty       = e;
		r.is_full        = f;
		return r;
	endfunction

	// shift up and place a value; full list refuses
	function automatic logic list_put(int unsigned pos, logic [PLE_DATA_WIDTH-1:0] v);
		int unsigned i;
		if (list_len >= PLE_CAPACITY)
			return 1'b0;
		if (pos > list_len)
			pos = list_len;
		for (i = list_len; i > pos; i--)
			list_vals[i] = list_vals[i - 1];
		list_vals[pos] = v;
		list_len++;
		return 1'b1;
	endfunction

	// close the gap left by a removed entry
	function automatic logic list_take(int unsigned pos);
		int unsigned i;
		if (pos >= list_len)
			return 1'b0;
		for (i = pos; i + 1 < list_len; i++)
			list_vals[i] = list_vals[i + 1];
		list_len--;
		return 1'b1;
	endfunction

	// apply one request to the list and return the result it should give
	function automatic ple_result_t apply_list_op(ple_cmd_t c);
		ple_result_t               r;
		int unsigned               p;
		int                        i;
		logic [PLE_DATA_WIDTH-1:0] v;
		r = '0;
		p = c.position_in;
		v = c.data_in[PLE_DATA_WIDTH-1:0];
		case (c.action)
			ACT_INSERT: begin
				if (p < PLE_CAPACITY)
					r.ok = list_put(p, v);
			end
			ACT_INSERT_FRONT: r.ok = list_put(0, v);
			ACT_INSERT_BACK:  r.ok = list_put(list_len, v);
			ACT_REMOVE:       r.ok = list_take(p);
			ACT_REMOVE_FRONT: r.ok = list_take(0);
			ACT_REMOVE_BACK: begin
				if (list_len != 0)
					r.ok = list_take(list_len - 1);
			end
			ACT_SELECT: begin
				r.ok = 1'b1;
				if (list_len != 0)
					r.data_out = list_vals[(p < list_len) ? p : list_len - 1];
			end
			ACT_SEARCH: begin
				r.ok             = 1'b1;
				r.found_position = POS_W'(list_len);
				// walk down so the lowest match wins
				for (i = int'(list_len) - 1; i >= 0; i--)
					if (list_vals[i] == v)
						r.found_position = POS_W'(i);
			end
			ACT_REPLACE: begin
				if (p < list_len) begin
					list_vals[p] = v;
					r.ok         = 1'b1;
				end
			end
			default: ;
		endcase
		r.count    = POS_W'(list_len);
		r.is_empty = (list_len == 0);
		r.is_full  = (list_len >= PLE_CAPACITY);
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] result %0d: %s", $realtime, results_seen, msg);
	endtask

	task automatic compare_result(ple_result_t got);
		ple_result_t want;
		if (awaited_results.size() == 0) begin
			flag_mismatch($sformatf("unexpected result %p", got));
			return;
		end
		want = awaited_results.pop_front();
		if (got.ok !== want.ok)
			flag_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
		if (got.data_out !== want.data_out)
			flag_mismatch($sformatf("data_out got %h want %h", got.data_out, want.data_out));
		if (got.found_position !== want.found_position)
			flag_mismatch($sformatf("found_position got %0d want %0d",
				got.found_position, want.found_position));
		if (got.count !== want.count)
			flag_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
		if (got.is_empty !== want.is_empty)
			flag_mismatch($sformatf("is_empty got %b want %b", got.is_empty, want.is_empty));
		if (got.is_full !== want.is_full)
			flag_mismatch($sformatf("is_full got %b want %b", got.is_full, want.is_full));
	endtask

	// request and result monitor, plus the stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (cmd_if.valid && cmd_if.ready) begin
				ple_result_t predicted;
				predicted = apply_list_op(cmd_if.payload);
				awaited_results.push_back(offer_fixed ? offer_want : predicted);
				quiet_cycles = 0;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				compare_result(rsp_if.payload);
				results_seen++;
				quiet_cycles = 0;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// result side: random back-pressure and one long hold-off
	initial begin
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rsp_hold_req) begin
				rsp_hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					rsp_if.ready <= 1'b0;
					@(negedge clk);
				end
			end
			rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	function automatic int idle_gap();
		int n;
		n = 0;
		if (!calm)
			while ($urandom_range(99) < IDLE_PCT)
				n++;
		return n;
	endfunction

	// offer one request after a random gap, return at the negedge after acceptance
	task automatic offer_request(ple_cmd_t c, logic fixed, ple_result_t want);
		int gap;
		gap = idle_gap();
		repeat (gap) begin
			cmd_if.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_if.valid   <= 1'b1;
		cmd_if.payload <= c;
		offer_fixed     = fixed;
		offer_want      = want;
		do
			@(posedge clk);
		while (!(cmd_if.valid && cmd_if.ready));
		@(negedge clk);
	endtask

	function automatic logic [WORD_W-1:0] draw_value();
		case ($urandom_range(3))
			0:       return $urandom();
			1:       return WORD_W'($urandom_range(7));
			default: return VALUE_POOL[$urandom_range(VALUE_POOL_N - 1)];
		endcase
	endfunction

	// random request, weighted to grow, shrink or churn the list
	function automatic ple_cmd_t draw_request(op_mix_t mix);
		ple_cmd_t c;
		int       r;
		int       ins_w;
		int       rem_w;
		case (mix)
			MIX_GROW:   begin ins_w = 60; rem_w = 12; end
			MIX_SHRINK: begin ins_w = 15; rem_w = 57; end
			default:    begin ins_w = 35; rem_w = 30; end
		endcase
		c.data_in = draw_value();
		if ($urandom_range(9) < 7)
			c.position_in = POS_W'($urandom_range(list_len));
		else
			c.position_in = POS_W'($urandom_range(31));
		r = $urandom_range(99);
		if (r < ins_w) begin
			case ($urandom_range(2))
				0:       c.action = ACT_INSERT;
				1:       c.action = ACT_INSERT_FRONT;
				default: c.action = ACT_INSERT_BACK;
			endcase
		end else if (r < ins_w + rem_w) begin
			case ($urandom_range(2))
				0:       c.action = ACT_REMOVE;
				1:       c.action = ACT_REMOVE_FRONT;
				default: c.action = ACT_REMOVE_BACK;
			endcase
		end else if (r < 96) begin
			case ($urandom_range(2))
				0:       c.action = ACT_SELECT;
				1:       c.action = ACT_SEARCH;
				default: c.action = ACT_REPLACE;
			endcase
		end else begin
			c.action = ACT_UNUSED_LO + ACTION_W'($urandom_range(ACT_UNUSED_HI - ACT_UNUSED_LO));
		end
		// most searches look for a value that is present
		if (c.action == ACT_SEARCH && list_len != 0 && $urandom_range(9) < 6)
			c.data_in = list_vals[$urandom_range(list_len - 1)];
		return c;
	endfunction

	// stimulus
	initial begin
		ple_cmd_t c;
		op_mix_t  mix;
		int       k;
		int       n;
		arst_n         = 1'b0;
		cmd_if.valid   = 1'b0;
		cmd_if.payload = '0;
		offer_fixed    = 1'b0;
		offer_want     = '0;
		calm           = 1'b0;
		rsp_hold_req   = 1'b0;
		mismatch_count = 0;
		results_seen   = 0;
		quiet_cycles   = 0;
		list_len       = 0;

		// empty-list queries and refusals, extremes, then a short worked list
		directed_rows = '{
			'{ACT_SELECT,       5'd0,  32'h0000_0000, 1'b1, result_of(1, 0, 0, 0, 1, 0)},
			'{ACT_SEARCH,       5'd0,  32'h0000_0000, 1'b1, result_of(1, 0, 0, 0, 1, 0)},
			'{ACT_REMOVE_FRONT, 5'd0,  32'h0000_0000, 1'b1, result_of(0, 0, 0, 0, 1, 0)},
			'{ACT_REMOVE_BACK,  5'd0,  32'h0000_0000, 1'b1, result_of(0, 0, 0, 0, 1, 0)},
			'{ACT_REMOVE,       5'd0,  32'h0000_0000, 1'b1, result_of(0, 0, 0, 0, 1, 0)},
			'{ACT_REPLACE,      5'd0,  32'h0000_0001, 1'b1, result_of(0, 0, 0, 0, 1, 0)},
			'{ACT_INSERT,       5'd31, 32'h0000_0005, 1'b1, result_of(0, 0, 0, 0, 1, 0)},
			'{ACT_INSERT,       5'd16, 32'h0000_0005, 1'b1, result_of(0, 0, 0, 0, 1, 0)},
			'{ACT_INSERT,       5'd5,  32'h7FFF_FFFF, 1'b1, result_of(1, 0, 0, 1, 0, 0)},
			'{ACT_INSERT_FRONT, 5'd0,  32'h8000_0000, 1'b1, result_of(1, 0, 0, 2, 0, 0)},
			'{ACT_INSERT_BACK,  5'd0,  32'hFFFF_FFFF, 1'b1, result_of(1, 0, 0, 3, 0, 0)},
			'{ACT_INSERT,       5'd1,  32'h0000_0001, 1'b1, result_of(1, 0, 0, 4, 0, 0)},
			'{ACT_SELECT,       5'd31, 32'h0000_0000, 1'b1,
				result_of(1, 32'hFFFF_FFFF, 0, 4, 0, 0)},
			'{ACT_SELECT,       5'd0,  32'h0000_0000, 1'b1,
				result_of(1, 32'h8000_0000, 0, 4, 0, 0)},
			'{ACT_SEARCH,       5'd0,  32'h7FFF_FFFF, 1'b1, result_of(1, 0, 2, 4, 0, 0)},
			'{ACT_SEARCH,       5'd0,  32'h1234_5678, 1'b1, result_of(1, 0, 4, 4, 0, 0)},
			'{ACT_REPLACE,      5'd1,  32'hA5A5_A5A5, 1'b0, '0},
			'{ACT_REPLACE,      5'd4,  32'h0000_0002, 1'b1, result_of(0, 0, 0, 4, 0, 0)},
			'{ACT_REMOVE,       5'd4,  32'h0000_0000, 1'b1, result_of(0, 0, 0, 4, 0, 0)},
			'{ACT_REMOVE,       5'd1,  32'h0000_0000, 1'b0, '0},
			'{ACT_UNUSED_LO,    5'd0,  32'h0000_0000, 1'b1, result_of(0, 0, 0, 3, 0, 0)},
			'{ACT_UNUSED_HI,    5'd31, 32'hFFFF_FFFF, 1'b1, result_of(0, 0, 0, 3, 0, 0)},
			'{ACT_REMOVE_FRONT, 5'd0,  32'h0000_0000, 1'b0, '0},
			'{ACT_REMOVE_BACK,  5'd0,  32'h0000_0000, 1'b0, '0},
			'{ACT_SEARCH,       5'd0,  32'h7FFF_FFFF, 1'b0, '0}
		};

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (k = 0; k < DIRECTED_ROWS; k++) begin
			c.action      = directed_rows[k].action;
			c.position_in = directed_rows[k].pos;
			c.data_in     = directed_rows[k].data;
			offer_request(c, directed_rows[k].fixed, directed_rows[k].want);
		end

		// random phases: grow, churn, shrink, churn, and the same again
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= CALM_FIRST && n < CALM_LAST);
			if (n == HOLD_AT_ITEM)
				rsp_hold_req = 1'b1;
			if (n == PAUSE_AT_ITEM) begin
				cmd_if.valid <= 1'b0;
				while (awaited_results.size() != 0)
					@(negedge clk);
				@(negedge clk);
			end
			case ((n / 125) % 4)
				0:       mix = MIX_GROW;
				2:       mix = MIX_SHRINK;
				default: mix = MIX_BALANCED;
			endcase
			offer_request(draw_request(mix), 1'b0, '0);
		end
		cmd_if.valid <= 1'b0;
		calm = 1'b0;

		// drain and settle
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (awaited_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
